// File: design/dhpq_pkg.sv
package dhpq_pkg;

	localparam int DEF_CAPACITY = 1024;
	localparam int DEF_ARITY    = 5;
	localparam int DEF_KEY_BITS = 32;

	localparam int CMD_W   = 3;
	localparam int KEYIO_W = 32;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 11;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT   = 3'd0,
		CMD_DEL_HIGH = 3'd1,
		CMD_DEL_LOW  = 3'd2,
		CMD_PEEK_HIGH = 3'd3,
		CMD_PEEK_LOW = 3'd4
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [KEYIO_W-1:0] key_in;
	} req_t;

	typedef struct packed {
		logic [KEYIO_W-1:0] key_out;
		logic [STAT_W-1:0]  status;
		logic [COUNT_W-1:0] element_count;
	} rsp_t;

endpackage

// File: design/dhpq_ram.sv
module dhpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/dary_heap_priority_queue.sv
// channel | direction | handshake       | payload
// req     | in        | req_valid/ready | req_t   (command, key_in)
// rsp     | out       | rsp_valid/ready | rsp_t   (key_out, status, element_count)
// cfg     | in        | cfg_we          | cfg_data (order_mode)
// one command at a time; the heap lives in one ram with one write port and a registered read
// insert: sift up reads a parent, then compares and writes; delete highest: fetch root and last,
// then the root check, then sift down reading the children of each level before its write
// lowest commands scan all leaves, one read per cycle, then finish like the highest ones
// peek highest: fetch the root into key_out; every command ends in a state
// that loads the response register; req_ready stays free while rsp waits, and a finished
// command stalls only while the previous response is still held
// arst_n clears count, order and control; ram contents are never cleared
module dary_heap_priority_queue import dhpq_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY,
	parameter int ARITY    = DEF_ARITY,
	parameter int KEY_BITS = DEF_KEY_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp,
	input  logic cfg_we,
	input  logic cfg_data
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int CAW = $clog2(ARITY + 1);
	localparam int PSH = AW + $clog2(ARITY);
	localparam int PMUL = ((1 << PSH) + ARITY - 1) / ARITY;
	localparam int PW = AW + PSH + 1;

	typedef enum logic [3:0] {
		S_IDLE, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_CMP, S_DN_W2,
		S_LO_RD, S_LO_CMP, S_RM_RD, S_RM_W, S_PK_RD, S_PK_W, S_RSP_WAIT
	} state_t;

	state_t state_q;
	logic [CW-1:0] count_q;
	logic order_q;
	logic [CMD_W-1:0] cmd_q;
	logic [AW-1:0] idx_q, best_q, ptr_q, low_q;
	logic [KEY_BITS-1:0] cur_q, best_key_q, low_key_q, kout_q;
	logic [CAW-1:0] ci_q;
	logic up_mode_q;
	logic pend_q;
	rsp_t pend_rsp_q;
	rsp_t res_q;
	logic out_free;

	logic ram_we;
	logic [AW-1:0] ram_wa, ram_ra;
	logic [KEY_BITS-1:0] ram_wd, ram_rd;

	dhpq_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_ram (
		.clk, .we(ram_we), .waddr(ram_wa), .wdata(ram_wd), .raddr(ram_ra), .rdata(ram_rd)
	);

	function automatic logic beats(input logic mode, input logic [KEY_BITS-1:0] a,
		input logic [KEY_BITS-1:0] b);
		beats = mode ? (a > b) : (a < b);
	endfunction

	// parent index by reciprocal multiplication
	function automatic logic [AW-1:0] parent(input logic [AW-1:0] i);
		logic [PW-1:0] prod;
		prod = PW'(i - AW'(1)) * PW'(PMUL);
		parent = AW'(prod >> PSH);
	endfunction

	logic [AW+CAW:0] first_c, child_c;
	logic [KEY_BITS-1:0] key_in_m;
	logic [CW-1:0] cnt_m1;
	assign first_c = (AW+CAW+1)'(idx_q) * (AW+CAW+1)'(ARITY) + (AW+CAW+1)'(1);
	assign child_c = first_c + (AW+CAW+1)'(ci_q);
	assign key_in_m = KEY_BITS'(req.key_in);
	assign cnt_m1 = count_q - CW'(1);

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = pend_q;
	assign rsp = pend_rsp_q;
	assign out_free = !pend_q || rsp_ready;

	// ram port control
	always_comb begin
		ram_we = 1'b0;
		ram_wa = idx_q;
		ram_wd = cur_q;
		ram_ra = idx_q;
		case (state_q)
			S_IDLE: begin
				ram_we = req_valid && req_ready && req.command == CMD_INSERT
					&& count_q < CW'(CAPACITY);
				ram_wa = AW'(count_q);
				ram_wd = key_in_m;
				ram_ra = AW'(cnt_m1);
			end
			S_UP_RD: ram_ra = parent(idx_q);
			S_UP_CMP: begin
				// sift up write: parent moves down into idx while cur beats it, else cur is written at idx
				ram_we = 1'b1;
				ram_wa = idx_q;
				ram_wd = beats(order_q, cur_q, ram_rd) && idx_q != '0 ? ram_rd : cur_q;
			end
			S_DN_RD: ram_ra = AW'(child_c);
			S_DN_CMP: ram_ra = AW'(child_c);
			S_DN_W2: begin
				ram_we = 1'b1;
				ram_wa = idx_q;
				ram_wd = (best_q != idx_q) ? best_key_q : cur_q;
			end
			S_LO_RD, S_LO_CMP: ram_ra = ptr_q;
			S_RM_RD: ram_ra = AW'(cnt_m1);
			S_PK_RD: ram_ra = idx_q;
			default: ;
		endcase
	end

	// control sequencer and registered response
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			order_q <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				order_q <= cfg_data;
			end
			// output register: load a finished transaction once the slot is free
			if (state_q == S_RSP_WAIT && out_free) begin
				pend_q <= 1'b1;
				pend_rsp_q <= res_q;
			end else if (pend_q && rsp_ready) begin
				pend_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid && req_ready) begin
						cmd_q <= req.command;
						kout_q <= '0;
						res_q.key_out <= '0;
						case (req.command)
							CMD_INSERT: begin
								if (count_q >= CW'(CAPACITY)) begin
									res_q.status <= ST_FULL;
									res_q.element_count <= COUNT_W'(count_q);
									state_q <= S_RSP_WAIT;
								end else begin
									res_q.status <= ST_OK;
									count_q <= count_q + CW'(1);
									res_q.element_count <= COUNT_W'(count_q + CW'(1));
									idx_q <= AW'(count_q);
									cur_q <= key_in_m;
									state_q <= S_UP_RD;
								end
							end
							CMD_DEL_HIGH, CMD_DEL_LOW, CMD_PEEK_HIGH, CMD_PEEK_LOW: begin
								res_q.element_count <= COUNT_W'(count_q);
								if (count_q == '0) begin
									res_q.status <= ST_EMPTY;
									state_q <= S_RSP_WAIT;
								end else begin
									res_q.status <= ST_OK;
									if (req.command == CMD_DEL_HIGH
										|| req.command == CMD_PEEK_HIGH || count_q == CW'(1)) begin
										idx_q <= '0;
										state_q <= S_PK_RD;
									end else begin
										// first leaf is parent of last plus one
										ptr_q <= parent(AW'(cnt_m1)) + AW'(1);
										low_q <= parent(AW'(cnt_m1)) + AW'(1);
										state_q <= S_LO_RD;
									end
								end
							end
							default: begin
								res_q.status <= ST_OK;
								res_q.element_count <= COUNT_W'(count_q);
								state_q <= S_RSP_WAIT;
							end
						endcase
					end
				end
				S_PK_RD: state_q <= S_PK_W;
				S_PK_W: begin
					kout_q <= ram_rd;
					if (cmd_q == CMD_PEEK_HIGH || cmd_q == CMD_PEEK_LOW) begin
						res_q.key_out <= KEYIO_W'(ram_rd);
						state_q <= S_RSP_WAIT;
					end else begin
						state_q <= S_RM_RD;
					end
				end
				// leaf scan: one read per cycle, first lowest kept
				S_LO_RD: begin
					ptr_q <= ptr_q + AW'(1);
					state_q <= S_LO_CMP;
				end
				S_LO_CMP: begin
					if (ptr_q == AW'(low_q) + AW'(1) || beats(order_q, low_key_q, ram_rd)
						|| (ptr_q - AW'(1)) == low_q) begin
						if ((ptr_q - AW'(1)) == low_q || beats(order_q, low_key_q, ram_rd)) begin
							low_q <= ptr_q - AW'(1);
							low_key_q <= ram_rd;
						end
					end
					if ((ptr_q - AW'(1)) == AW'(cnt_m1)) begin
						idx_q <= ((ptr_q - AW'(1)) != low_q && beats(order_q, low_key_q, ram_rd))
							|| (ptr_q - AW'(1)) == low_q ? ptr_q - AW'(1) : low_q;
						state_q <= S_PK_RD;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				S_RM_RD: begin
					count_q <= cnt_m1;
					res_q.element_count <= COUNT_W'(cnt_m1);
					res_q.key_out <= KEYIO_W'(kout_q);
					state_q <= S_RM_W;
				end
				S_RM_W: begin
					cur_q <= ram_rd;
					up_mode_q <= 1'b1;
					if (CW'(idx_q) >= count_q) begin
						state_q <= S_RSP_WAIT;
					end else begin
						state_q <= S_UP_RD;
					end
				end
				// sift up: read parent, compare, move parent down
				S_UP_RD: state_q <= S_UP_CMP;
				S_UP_CMP: begin
					if (idx_q != '0 && beats(order_q, cur_q, ram_rd)) begin
						idx_q <= parent(idx_q);
						up_mode_q <= 1'b0;
						state_q <= S_UP_RD;
					end else if (up_mode_q && cmd_q != CMD_INSERT) begin
						// no move up: go down instead
						ci_q <= '0;
						best_q <= idx_q;
						best_key_q <= cur_q;
						state_q <= S_DN_RD;
					end else begin
						state_q <= S_RSP_WAIT;
					end
				end
				// sift down: stream children, track best
				S_DN_RD: begin
					if (ci_q >= CAW'(ARITY) || child_c >= (AW+CAW+1)'(count_q)) begin
						state_q <= S_DN_W2;
					end else begin
						ci_q <= ci_q + CAW'(1);
						state_q <= S_DN_CMP;
					end
				end
				S_DN_CMP: begin
					if (beats(order_q, ram_rd, best_key_q)) begin
						best_key_q <= ram_rd;
						best_q <= AW'(child_c - (AW+CAW+1)'(1));
					end
					if (ci_q >= CAW'(ARITY) || child_c >= (AW+CAW+1)'(count_q)) begin
						state_q <= S_DN_W2;
					end else begin
						ci_q <= ci_q + CAW'(1);
					end
				end
				S_DN_W2: begin
					if (best_q != idx_q) begin
						idx_q <= best_q;
						best_key_q <= cur_q;
						ci_q <= '0;
						state_q <= S_DN_RD;
					end else begin
						state_q <= S_RSP_WAIT;
					end
				end
				// hold the finished transaction until the response register is free
				S_RSP_WAIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: design/dhpq_checker.sv
module dhpq_checker import dhpq_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp
);

	// response held while stalled
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// one command at a time: ready drops after an accepted request
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while busy");

	// status code in range
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status == ST_OK || rsp.status == ST_EMPTY || rsp.status == ST_FULL)
		else $error("bad status");

	// errors carry a zero key
	a_err_key: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.key_out == '0)
		else $error("nonzero key on error");

endmodule

bind dary_heap_priority_queue dhpq_checker u_chk (
	.clk, .arst_n, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp
);
